/* hw/rtl/bb3_pkg.sv */
// Shared constants, types and codes for the edge-aware 3x3 box blur.
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (WID_W > HGT_W) ? WID_W : HGT_W;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(1024);

    typedef logic [PIX_W-1:0]              t_pix;
    typedef logic [2:0][PIX_W-1:0]         t_col;
    typedef logic [2:0][2:0][PIX_W-1:0]    t_win;
    typedef logic [2*PIX_W-1:0]            t_line_word;

    typedef struct packed {
        logic [2:0] rmask;
        logic [2:0] cmask;
        logic       frame_end;
    } t_avg_req;

    typedef struct packed {
        t_pix pix;
        logic frame_end;
    } t_avg_res;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } t_action;

endpackage

/* hw/rtl/bb3_line_ram.sv */
// Line buffer memory: one word per column holding the upper and middle line pixels.
module bb3_line_ram (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [bb3_pkg::COL_W-1:0]  i_rd_addr,
    output bb3_pkg::t_line_word        o_rd_data,
    input  logic                       i_wr_en,
    input  logic [bb3_pkg::COL_W-1:0]  i_wr_addr,
    input  bb3_pkg::t_line_word        i_wr_data
);
    import bb3_pkg::*;

    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/bb3_avg.sv */
// Three-stage masked neighborhood averager with half-up rounding.
module bb3_avg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bb3_pkg::t_win     i_win,
    input  bb3_pkg::t_avg_req i_req,
    output logic              o_valid,
    output bb3_pkg::t_avg_res o_res
);
    import bb3_pkg::*;

    localparam int SUM_W  = 12;
    localparam int NUM_W  = SUM_W + 1;
    localparam int X_W    = 12;
    localparam int MUL_W  = 12;
    localparam int PROD_W = X_W + MUL_W;
    localparam int SHR_W  = 4;
    localparam int CNT_W  = 4;

    localparam logic [MUL_W-1:0] RECIP_1 = MUL_W'(1);
    localparam logic [MUL_W-1:0] RECIP_3 = MUL_W'(2731);
    localparam logic [MUL_W-1:0] RECIP_9 = MUL_W'(3641);

    typedef struct packed {
        logic [1:0]       pre_shift;
        logic [MUL_W-1:0] recip;
        logic [SHR_W-1:0] post_shift;
    } t_div_plan;

    function automatic t_div_plan plan_for(input logic [CNT_W-1:0] count);
        t_div_plan p;
        p.pre_shift  = 2'd1;
        p.recip      = RECIP_1;
        p.post_shift = SHR_W'(0);
        case (count)
            CNT_W'(2): begin
                p.pre_shift = 2'd2;
            end
            CNT_W'(3): begin
                p.recip      = RECIP_3;
                p.post_shift = SHR_W'(13);
            end
            CNT_W'(4): begin
                p.pre_shift = 2'd3;
            end
            CNT_W'(6): begin
                p.pre_shift  = 2'd2;
                p.recip      = RECIP_3;
                p.post_shift = SHR_W'(13);
            end
            CNT_W'(9): begin
                p.recip      = RECIP_9;
                p.post_shift = SHR_W'(15);
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    logic [2:0][SUM_W-1:0]  n_s1_sum;
    logic [CNT_W-1:0]       n_s1_count;
    logic [2:0][SUM_W-1:0]  r_s1_sum;
    logic [CNT_W-1:0]       r_s1_count;
    logic                   r_s1_fe;
    logic                   r_s1_valid;

    t_div_plan              plan;
    logic [2:0][PROD_W-1:0] n_s2_prod;
    logic [2:0][PROD_W-1:0] r_s2_prod;
    logic [SHR_W-1:0]       r_s2_post;
    logic                   r_s2_fe;
    logic                   r_s2_valid;

    t_pix                   n_s3_pix;
    t_pix                   r_s3_pix;
    logic                   r_s3_fe;
    logic                   r_s3_valid;

    always_comb begin
        logic [1:0] rc;
        logic [1:0] cc;
        n_s1_sum = '0;
        for (int col = 0; col < 3; col++) begin
            for (int row = 0; row < 3; row++) begin
                if (i_req.cmask[col] && i_req.rmask[row]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        n_s1_sum[ch] = n_s1_sum[ch]
                                     + SUM_W'(i_win[col][row][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
        rc = 2'($countones(i_req.rmask));
        cc = 2'($countones(i_req.cmask));
        n_s1_count = CNT_W'(rc) * CNT_W'(cc);
    end

    always_comb begin
        logic [NUM_W-1:0] num;
        logic [X_W-1:0]   x;
        plan = plan_for(r_s1_count);
        for (int ch = 0; ch < 3; ch++) begin
            num = {r_s1_sum[ch], 1'b0} + NUM_W'(r_s1_count);
            x   = X_W'(num >> plan.pre_shift);
            n_s2_prod[ch] = PROD_W'(x) * PROD_W'(plan.recip);
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_s3_pix[ch*CH_W +: CH_W] = CH_W'(r_s2_prod[ch] >> r_s2_post);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sum   <= n_s1_sum;
        r_s1_count <= n_s1_count;
        r_s1_fe    <= i_req.frame_end;
        r_s2_prod  <= n_s2_prod;
        r_s2_post  <= plan.post_shift;
        r_s2_fe    <= r_s1_fe;
        r_s3_pix   <= n_s3_pix;
        r_s3_fe    <= r_s2_fe;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign o_valid       = r_s3_valid;
    assign o_res.pix       = r_s3_pix;
    assign o_res.frame_end = r_s3_fe;

endmodule

/* hw/rtl/box_blur_3x3_edge_aware_unit.sv */
// Top level of the edge-aware 3x3 box blur: sequencer, window, positions and output register.
//
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata red,green,blue; tuser action
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata red,green,blue; tlast frame_end
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// A pixel item yields no, one or two results; input is held off until the item is done.
// A drain item yields one result; the first column of the drain takes an extra RAM read step.
// The single line RAM port and the shared three-stage averager set these item steps.
// Synchronous active-low reset clears positions, drain state and valid flags;
// the line RAM has no reset. A stalled output holds the next result in the averager issue step.
// A pending configuration write holds off input items.
module box_blur_3x3_edge_aware_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bb3_pkg::PIX_W-1:0]         s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                              s_axis_tuser,  // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bb3_pkg::PIX_W-1:0]         m_axis_tdata,  // red_out, green_out, blue_out
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bb3_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PXRD = 6'b000010,
        S_DRD0 = 6'b000100,
        S_DRD  = 6'b001000,
        S_EMIT = 6'b010000,
        S_CALC = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [WID_W-1:0]  r_width, n_width;
    logic [HGT_W-1:0]  r_height, n_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_drain, n_drain;
    logic              r_draining, n_draining;
    t_win              r_win, n_win;
    t_pix              r_px, n_px;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    t_avg_req          r_req, n_req;
    logic [2:0]        r_cmask2, n_cmask2;
    logic              r_more, n_more;
    logic              r_out_valid, n_out_valid;
    t_pix              r_out_pix, n_out_pix;
    logic              r_out_last, n_out_last;

    logic              in_accept;
    logic [COL_W-1:0]  pix_col;
    logic              ram_rd_en;
    logic [COL_W-1:0]  ram_rd_addr;
    t_line_word        ram_rd_data;
    logic              ram_wr_en;
    t_line_word        ram_wr_data;
    t_pix              ram_upper;
    t_pix              ram_middle;
    logic              avg_start;
    logic              avg_valid;
    t_avg_res          avg_res;
    logic [WID_W-1:0]  cfg_w;
    logic [HGT_W-1:0]  cfg_h;

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pix_col       = (WID_W'(r_col) >= r_width) ? '0 : r_col;
    assign ram_upper     = ram_rd_data[2*PIX_W-1:PIX_W];
    assign ram_middle    = ram_rd_data[PIX_W-1:0];
    assign ram_wr_data   = {ram_middle, r_px};
    assign cfg_w         = i_cfg_data[WID_W-1:0];
    assign cfg_h         = i_cfg_data[HGT_W-1:0];

    bb3_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_cur_col),
        .i_wr_data (ram_wr_data)
    );

    bb3_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (avg_start),
        .i_win   (r_win),
        .i_req   (r_req),
        .o_valid (avg_valid),
        .o_res   (avg_res)
    );

    always_comb begin
        logic last_col;
        logic has_above;
        logic [2:0] rmask;
        logic [2:0] cm1;
        logic [2:0] cm2;
        logic d_last;
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_col       = r_col;
        n_row       = r_row;
        n_drain     = r_drain;
        n_draining  = r_draining;
        n_win       = r_win;
        n_px        = r_px;
        n_cur_col   = r_cur_col;
        n_req       = r_req;
        n_cmask2    = r_cmask2;
        n_more      = r_more;
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_last  = r_out_last;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        ram_wr_en   = 1'b0;
        avg_start   = 1'b0;
        last_col    = (WID_W'(r_cur_col) + WID_W'(1)) == r_width;
        has_above   = (r_row != '0);
        rmask       = {1'b1, 1'b1, r_row >= ROW_W'(2)};
        cm1         = {1'b1, 1'b1, r_cur_col >= COL_W'(2)};
        cm2         = {1'b1, r_cur_col != '0, 1'b0};
        d_last      = (WID_W'(r_drain) + WID_W'(1)) == r_width;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (t_action'(s_axis_tuser) == ACT_DRAIN) begin
                        if (r_draining) begin
                            ram_rd_en = 1'b1;
                            if (r_drain == '0) begin
                                n_state = S_DRD0;
                            end else begin
                                ram_rd_addr = r_drain + COL_W'(1);
                                n_state     = S_DRD;
                            end
                        end
                    end else if (!r_draining) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pix_col;
                        n_px        = s_axis_tdata;
                        n_cur_col   = pix_col;
                        n_state     = S_PXRD;
                    end
                end
            end
            S_PXRD: begin
                ram_wr_en = 1'b1;
                n_win[0]  = r_win[1];
                n_win[1]  = r_win[2];
                n_win[2]  = {r_px, ram_middle, ram_upper};
                n_req.rmask     = rmask;
                n_req.frame_end = 1'b0;
                n_more          = 1'b0;
                n_cmask2        = cm2;
                if (has_above && r_cur_col != '0) begin
                    n_req.cmask = cm1;
                    n_more      = last_col;
                    n_state     = S_EMIT;
                end else if (has_above && last_col) begin
                    n_req.cmask = cm2;
                    n_state     = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
                if (last_col) begin
                    n_col = '0;
                    if ((HGT_W'(r_row) + HGT_W'(1)) >= r_height) begin
                        n_row      = '0;
                        n_draining = 1'b1;
                        n_drain    = '0;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_cur_col + COL_W'(1);
                end
            end
            S_DRD0: begin
                n_win[0]    = r_win[1];
                n_win[1]    = r_win[2];
                n_win[2]    = {PIX_W'(0), ram_middle, ram_upper};
                ram_rd_en   = 1'b1;
                ram_rd_addr = COL_W'(1);
                n_state     = S_DRD;
            end
            S_DRD: begin
                n_win[0] = r_win[1];
                n_win[1] = r_win[2];
                n_win[2] = {PIX_W'(0), ram_middle, ram_upper};
                n_req.rmask     = {1'b0, 1'b1, r_height >= HGT_W'(2)};
                n_req.cmask     = {!d_last, 1'b1, r_drain != '0};
                n_req.frame_end = d_last;
                n_more          = 1'b0;
                if (d_last) begin
                    n_draining = 1'b0;
                    n_drain    = '0;
                end else begin
                    n_drain = r_drain + COL_W'(1);
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    avg_start = 1'b1;
                    n_state   = S_CALC;
                end
            end
            S_CALC: begin
                if (avg_valid) begin
                    if (r_more) begin
                        n_more      = 1'b0;
                        n_req.cmask = r_cmask2;
                        n_state     = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (avg_valid) begin
            n_out_valid = 1'b1;
            n_out_pix   = avg_res.pix;
            n_out_last  = avg_res.frame_end;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH: begin
                    if (cfg_w == '0) begin
                        n_width = WID_W'(1);
                    end else if (cfg_w > WID_W'(MAX_WIDTH)) begin
                        n_width = WID_W'(MAX_WIDTH);
                    end else begin
                        n_width = cfg_w;
                    end
                end
                CFG_HEIGHT: begin
                    if (cfg_h == '0) begin
                        n_height = HGT_W'(1);
                    end else if (cfg_h > HGT_W'(MAX_HEIGHT)) begin
                        n_height = HGT_W'(MAX_HEIGHT);
                    end else begin
                        n_height = cfg_h;
                    end
                end
                default: begin
                end
            endcase
            n_col      = '0;
            n_row      = '0;
            n_drain    = '0;
            n_draining = 1'b0;
            n_more     = 1'b0;
            n_state    = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_px       <= n_px;
        r_cur_col  <= n_cur_col;
        r_req      <= n_req;
        r_cmask2   <= n_cmask2;
        r_out_pix  <= n_out_pix;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_drain     <= '0;
            r_draining  <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_drain     <= n_drain;
            r_draining  <= n_draining;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avg_valid |-> (!r_out_valid || m_axis_tready))
        else $error("averager result would overwrite a waiting item");

    a_calc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avg_valid |-> (r_state == S_CALC))
        else $error("averager result outside the wait step");

    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("line RAM read and write overlap");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WID_W'(r_col) < r_width)
        else $error("column position beyond image width");

    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (WID_W'(r_drain) < r_width))
        else $error("drain position beyond image width");

endmodule

/* test/tb_box_blur_3x3_edge_aware_unit.sv */
// Self-checking testbench for the edge-aware 3x3 box blur: directed frames, random frames, stalls.
module tb_box_blur_3x3_edge_aware_unit;
    import bb3_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 120;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_blur_px;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int unsigned img_w    = 1024;
    int unsigned img_h    = 1024;
    int unsigned col_at   = 0;
    int unsigned row_at   = 0;
    int unsigned drain_at = 0;
    bit          draining = 1'b0;
    t_pix        upper_rows [MAX_WIDTH];
    t_pix        middle_rows [MAX_WIDTH];
    t_win        live_win = '0;

    t_blur_px    blurred_pending [$];
    int          fail_count      = 0;
    int          effective_items = 0;
    bit          tx_calm         = 1'b0;
    bit          rx_calm         = 1'b0;
    int          rx_hold_cycles  = 0;

    box_blur_3x3_edge_aware_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_blur_px box_average(t_win g, logic [2:0] rmask, logic [2:0] cmask,
                                             logic last);
        int unsigned sr = 0;
        int unsigned sg = 0;
        int unsigned sb = 0;
        int unsigned n  = 0;
        t_blur_px    res;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (rmask[r] && cmask[c]) begin
                    sr += g[r][c][23:16];
                    sg += g[r][c][15:8];
                    sb += g[r][c][7:0];
                    n++;
                end
            end
        end
        if (n == 0) n = 1;
        res.red   = 8'((2 * sr + n) / (2 * n));
        res.green = 8'((2 * sg + n) / (2 * n));
        res.blue  = 8'((2 * sb + n) / (2 * n));
        res.last  = last;
        return res;
    endfunction

    // Returns 1 when the item moves the frame along, 0 when the block drops it.
    function automatic bit advance_blur(t_action act, t_pix px);
        t_win        g;
        int unsigned c;
        int unsigned r;
        int unsigned d;
        logic [2:0]  rmask;
        logic [2:0]  cmask;
        t_pix        up;
        t_pix        mid;
        g = '0;
        if (act == ACT_DRAIN) begin
            d = drain_at;
            if (!draining || d >= img_w) return 1'b0;
            cmask = 3'b010;
            g[0][1] = upper_rows[d];
            g[1][1] = middle_rows[d];
            if (d >= 1) begin
                g[0][0] = upper_rows[d-1];
                g[1][0] = middle_rows[d-1];
                cmask[0] = 1'b1;
            end
            if (d + 1 < img_w) begin
                g[0][2] = upper_rows[d+1];
                g[1][2] = middle_rows[d+1];
                cmask[2] = 1'b1;
            end
            rmask = {1'b0, 1'b1, img_h >= 2};
            blurred_pending.push_back(box_average(g, rmask, cmask, d + 1 == img_w));
            if (d + 1 == img_w) begin
                draining = 1'b0;
                drain_at = 0;
            end else begin
                drain_at = d + 1;
            end
            return 1'b1;
        end
        if (draining) return 1'b0;
        c = col_at;
        r = row_at;
        if (c >= img_w) c = 0;
        up  = upper_rows[c];
        mid = middle_rows[c];
        upper_rows[c]  = mid;
        middle_rows[c] = px;
        for (int k = 0; k < 3; k++) begin
            live_win[k][0] = live_win[k][1];
            live_win[k][1] = live_win[k][2];
        end
        live_win[0][2] = up;
        live_win[1][2] = mid;
        live_win[2][2] = px;
        if (r >= 1) begin
            rmask = {1'b1, 1'b1, r >= 2};
            if (c >= 1)
                blurred_pending.push_back(box_average(live_win, rmask, {2'b11, c >= 2}, 1'b0));
            if (c + 1 == img_w) begin
                for (int k = 0; k < 3; k++) begin
                    g[k][0] = live_win[k][1];
                    g[k][1] = live_win[k][2];
                end
                blurred_pending.push_back(box_average(g, rmask, {2'b01, c >= 1}, 1'b0));
            end
        end
        if (c + 1 == img_w) begin
            col_at = 0;
            if (r + 1 >= img_h) begin
                row_at   = 0;
                draining = 1'b1;
                drain_at = 0;
            end else begin
                row_at = r + 1;
            end
        end else begin
            col_at = c + 1;
        end
        return 1'b1;
    endfunction

    function automatic void apply_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        if (idx == CFG_WIDTH) begin
            v = 32'(data[10:0]);
            img_w = (v < 1) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
        end else begin
            v = 32'(data);
            img_h = (v < 1) ? 1 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
        end
        col_at   = 0;
        row_at   = 0;
        drain_at = 0;
        draining = 1'b0;
    endfunction

    function automatic t_pix rand_pix();
        return t_pix'($urandom);
    endfunction

    function automatic void check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_blur_px want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blurred_pending.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item, expected none actual %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = blurred_pending.pop_front();
                check_field("red", want.red, m_axis_tdata[7:0]);
                check_field("green", want.green, m_axis_tdata[15:8]);
                check_field("blue", want.blue, m_axis_tdata[23:16]);
                check_field("last", 8'(want.last), 8'(m_axis_tlast));
            end
        end
    end

    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (rx_hold_cycles != 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(t_action act, t_pix px);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {px[7:0], px[15:8], px[23:16]};
        do @(posedge i_clk); while (!s_axis_tready);
        if (advance_blur(act, px)) effective_items++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (blurred_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic run_frame(int unsigned n_pix, int unsigned n_drain);
        for (int unsigned i = 0; i < n_pix; i++) send_item(ACT_PIXEL, rand_pix());
        for (int unsigned i = 0; i < n_drain; i++) send_item(ACT_DRAIN, rand_pix());
    endtask

    task automatic test_reset_defaults();
        run_frame(4, 0);
    endtask

    task automatic test_single_pixel();
        set_frame(1, 1);
        send_item(ACT_PIXEL, 24'hFF0080);
        send_item(ACT_DRAIN, 24'h000000);
        send_item(ACT_PIXEL, 24'h00FF01);
        send_item(ACT_DRAIN, 24'hFFFFFF);
    endtask

    task automatic test_ignored_items();
        set_frame(2, 1);
        send_item(ACT_DRAIN, 24'hFFFFFF);
        send_item(ACT_PIXEL, 24'hFFFFFF);
        send_item(ACT_PIXEL, 24'h000000);
        send_item(ACT_PIXEL, 24'h123456);
        send_item(ACT_DRAIN, 24'h000000);
        send_item(ACT_DRAIN, 24'h000000);
        send_item(ACT_DRAIN, 24'h000000);
    endtask

    task automatic test_rounding_frame();
        set_frame(3, 2);
        send_item(ACT_PIXEL, 24'hFF00FF);
        send_item(ACT_PIXEL, 24'h00FF00);
        send_item(ACT_PIXEL, 24'hFFFFFF);
        send_item(ACT_PIXEL, 24'h000000);
        send_item(ACT_PIXEL, 24'hFF0001);
        send_item(ACT_PIXEL, 24'h01FF00);
        run_frame(0, 3);
    endtask

    task automatic test_register_saturation();
        set_frame(4096, 0);
        send_item(ACT_PIXEL, 24'hA5A5A5);
        send_item(ACT_DRAIN, 24'h5A5A5A);
        write_reg(CFG_WIDTH, 13'h1803);
        run_frame(3, 3);
    endtask

    task automatic test_random_frames();
        int          goal;
        bit          need_restart;
        bit          broken;
        int unsigned w;
        int unsigned cut;
        goal = effective_items + RANDOM_ITEMS;
        need_restart = 1'b1;
        while (effective_items < goal) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (need_restart || $urandom_range(0, 1) == 1) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                write_reg(CFG_WIDTH, CFG_DATA_W'(w) | CFG_DATA_W'($urandom_range(0, 3) << 11));
                write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(1, 6)));
            end
            broken = ($urandom_range(0, 7) == 0);
            cut = broken ? $urandom_range(0, img_w * img_h - 1) : img_w * img_h;
            for (int unsigned i = 0; i < cut; i++) begin
                if ($urandom_range(0, 15) == 0) send_item(ACT_DRAIN, rand_pix());
                send_item(ACT_PIXEL, rand_pix());
            end
            if (!broken) begin
                for (int unsigned i = 0; i < img_w; i++) begin
                    if ($urandom_range(0, 7) == 0) send_item(ACT_PIXEL, rand_pix());
                    send_item(ACT_DRAIN, rand_pix());
                end
            end
            need_restart = broken;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_frame(8, 6);
        tx_calm = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        run_frame(48, 8);
        tx_calm = 1'b0;
    endtask

    task automatic test_widest_frame();
        set_frame(2047, 1);
        run_frame(MAX_WIDTH, 4);
    endtask

    task automatic test_tallest_frame();
        set_frame(4, 4096);
        run_frame(12, 0);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        run_frame(8, 0);
        set_frame(1024, 2);
        run_frame(5, 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_single_pixel();
        test_ignored_items();
        test_rounding_frame();
        test_register_saturation();
        test_random_frames();
        test_output_backpressure();
        test_widest_frame();
        test_tallest_frame();
        settle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
